// File: design/bol_pkg.sv
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Sizes of the list, request and status codes, and the request, response
// and cell command beats.
// ----------------------------------------------------------------------------
package bol_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int LEN_W    = 5;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [2:0] {
    REQ_APPEND     = 3'd0,
    REQ_INSERT     = 3'd1,
    REQ_DELETE_POS = 3'd2,
    REQ_DELETE_VAL = 3'd3,
    REQ_SEARCH     = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_code_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } cell_act_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [LEN_W-1:0] length;
  } out_beat_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    cell_act_t        act;
    logic [IDX_W-1:0] k;
    logic [31:0]      data;
    logic             sample;
    logic [31:0]      probe;
  } cell_cmd_t;

endpackage

// File: design/bounded_ordered_list_core.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_core: ordered list of signed 32-bit values
// A row of cells, one per entry, with a count register and a request
// decoder that drives the whole row at once.
// ----------------------------------------------------------------------------
// Usage. A request beat (req) is taken at a rising edge where start is high
// and busy is low. It names one of append, insert at a 1-based position,
// delete at a position, delete the first entry equal to a value, search,
// or clear. Every request, served or refused, yields exactly one response
// beat on rsp, marked by done for a single cycle.
//
// Timing. The edge that takes a request also latches, in every cell, the
// comparison of its entry with the request value. In the next cycle busy is
// high: the first match and the position checks are resolved, and at the
// end of that cycle all cells shift or load together and the response is
// registered. done is high in the cycle after that. A new request is not
// taken while busy is high; the busy cycle exists for the first-match
// search over the row's latched compare flags.
//
// Reset is synchronous: it empties the list and clears busy and done. Entry
// contents are not reset, since slots above the count are never observed.
// The receiver cannot hold off a response, so there is no stall path.
// ----------------------------------------------------------------------------
module bounded_ordered_list_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bol_pkg::in_beat_t req,
  output logic              done,
  output bol_pkg::out_beat_t rsp
);

  localparam int N = bol_pkg::CAPACITY;

  bol_pkg::in_beat_t          req_q;
  logic [bol_pkg::CNT_W-1:0]  count;
  logic [bol_pkg::CNT_W-1:0]  count_next;
  bol_pkg::cell_cmd_t         cmd;
  bol_pkg::out_beat_t         rsp_next;

  logic [31:0]                entries [N];
  logic [N-1:0]               match_raw;
  logic [N-1:0]               match_live;
  logic [N-1:0]               first_hot;
  logic [bol_pkg::IDX_W-1:0]  first_idx;
  logic                       any_match;

  logic [bol_pkg::CMP_W-1:0]  pos_w;
  logic [bol_pkg::CMP_W-1:0]  cnt_w;
  logic [bol_pkg::CMP_W-1:0]  k_w;
  logic                       accept;
  logic                       full;

  assign accept = start && !busy;

  // Only slots below the count hold live entries.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match_live[i] = match_raw[i] && (bol_pkg::CNT_W'(i) < count);
    end
  end

  // Lowest set bit of the live match vector, then its index.
  assign first_hot = match_live & (~match_live + N'(1));
  assign any_match = |match_live;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < N; i++) begin
      first_idx = first_idx | (first_hot[i] ? bol_pkg::IDX_W'(i) : '0);
    end
  end

  assign pos_w = bol_pkg::CMP_W'(req_q.position);
  assign cnt_w = bol_pkg::CMP_W'(count);
  assign k_w   = pos_w - bol_pkg::CMP_W'(1);
  assign full  = (count >= bol_pkg::CNT_W'(N));

  // Request decode, active in the busy cycle.
  always_comb begin
    count_next      = count;
    rsp_next.status = bol_pkg::ST_DONE;
    rsp_next.found  = 1'b0;
    cmd.act         = bol_pkg::ACT_HOLD;
    cmd.k           = bol_pkg::IDX_W'(k_w);
    cmd.data        = req_q.value;
    cmd.sample      = accept;
    cmd.probe       = req.value;

    if (busy) begin
      unique case (req_q.req_type)
        bol_pkg::REQ_APPEND: begin
          if (full) begin
            rsp_next.status = bol_pkg::ST_FULL;
          end else begin
            cmd.act    = bol_pkg::ACT_INSERT;
            cmd.k      = bol_pkg::IDX_W'(count);
            count_next = count + bol_pkg::CNT_W'(1);
          end
        end
        bol_pkg::REQ_INSERT: begin
          if (pos_w == '0 || pos_w > cnt_w + bol_pkg::CMP_W'(1)) begin
            rsp_next.status = bol_pkg::ST_MISS;
          end else if (full) begin
            rsp_next.status = bol_pkg::ST_FULL;
          end else begin
            cmd.act    = bol_pkg::ACT_INSERT;
            count_next = count + bol_pkg::CNT_W'(1);
          end
        end
        bol_pkg::REQ_DELETE_POS: begin
          if (pos_w == '0 || pos_w > cnt_w) begin
            rsp_next.status = bol_pkg::ST_MISS;
          end else begin
            cmd.act    = bol_pkg::ACT_REMOVE;
            count_next = count - bol_pkg::CNT_W'(1);
          end
        end
        bol_pkg::REQ_DELETE_VAL: begin
          if (any_match) begin
            rsp_next.found = 1'b1;
            cmd.act        = bol_pkg::ACT_REMOVE;
            cmd.k          = first_idx;
            count_next     = count - bol_pkg::CNT_W'(1);
          end else begin
            rsp_next.status = bol_pkg::ST_MISS;
          end
        end
        bol_pkg::REQ_SEARCH: begin
          if (any_match) begin
            rsp_next.found = 1'b1;
          end else begin
            rsp_next.status = bol_pkg::ST_MISS;
          end
        end
        bol_pkg::REQ_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
    rsp_next.length = bol_pkg::LEN_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      busy  <= accept;
      done  <= busy;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (busy) begin
      rsp <= rsp_next;
    end
  end

  // The row of cells; each sees its two neighbors.
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [31:0] left_data;
    logic [31:0] right_data;

    if (g == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = entries[g-1];
    end

    if (g == N - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = entries[g+1];
    end

    bol_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (bol_pkg::IDX_W'(g)),
      .cmd   (cmd),
      .left  (left_data),
      .right (right_data),
      .entry (entries[g]),
      .match (match_raw[g])
    );
  end

endmodule

// File: design/bol_cell.sv
// ----------------------------------------------------------------------------
// bol_cell: one slot of the ordered list
// Holds one entry, compares it with a probe value, and on an insert or a
// remove loads the new value or the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module bol_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [bol_pkg::IDX_W-1:0] idx,
  input  bol_pkg::cell_cmd_t       cmd,
  input  logic [31:0]              left,
  input  logic [31:0]              right,
  output logic [31:0]              entry,
  output logic                     match
);

  logic [31:0] entry_next;

  always_comb begin
    entry_next = entry;
    unique case (cmd.act)
      bol_pkg::ACT_INSERT: begin
        if (idx == cmd.k) begin
          entry_next = cmd.data;
        end else if (idx > cmd.k) begin
          entry_next = left;
        end
      end
      bol_pkg::ACT_REMOVE: begin
        if (idx >= cmd.k) begin
          entry_next = right;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // The match flag is captured when a request is taken and used in the following busy cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmd.sample) begin
      match <= (entry == cmd.probe);
    end
  end

endmodule

// File: design/bol_checker.sv
// ----------------------------------------------------------------------------
// bol_checker: port-level checks for the ordered list core
// Watches the request handshake and the response beat over time.
// ----------------------------------------------------------------------------
module bol_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input bol_pkg::out_beat_t rsp
);

  // A taken request makes the core busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but core not busy");

  // Every busy cycle is followed by one response beat.
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (done && !busy))
    else $error("busy cycle not followed by a response");

  // A response only follows a busy cycle.
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("response without a request");

  // A full status only comes with a full list.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == bol_pkg::ST_FULL) |->
      (rsp.length == bol_pkg::LEN_W'(bol_pkg::CAPACITY)))
    else $error("full status with a list that is not full");

  // A match is always reported as served.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.found) |-> (rsp.status == bol_pkg::ST_DONE))
    else $error("found flag with a failing status");

endmodule

bind bounded_ordered_list_core bol_checker u_bol_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bounded_ordered_list_core
// Runs a scripted set of requests over the empty, single-entry and full list,
// then a long random stream that swings the list between empty and full.
// Every response is checked against its typed value or a queue-based shadow of the list.
// ----------------------------------------------------------------------------
module testbench;

  // Request codes that the block leaves undecoded; they must answer DONE
  // with the length unchanged.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 8;       // slack after the last response is checked
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run

  typedef struct {
    bol_pkg::in_beat_t  beat;
    int unsigned        reps;   // the same beat sent this many times in a row
    bit                 typed;  // 1: response written into the row, 0: from the shadow
    bol_pkg::out_beat_t want;
  } script_row_t;

  logic               clk;
  logic               rst   = 1'b1;
  logic               start = 1'b0;
  bol_pkg::in_beat_t  req   = '0;
  logic               busy;
  logic               done;
  bol_pkg::out_beat_t rsp;

  // Shadow of the list contents, position 1 first.
  logic [31:0]        list_mirror [$];
  // Responses owed by the block, in the order their requests were taken.
  bol_pkg::out_beat_t answers_due [$];
  script_row_t        directed_rows [$];

  logic [31:0] corner_values [6] = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                                     32'h8000_0000, 32'h7fff_ffff, 32'h0000_002a};

  int  errors = 0;
  int  checked = 0;
  int  sent_directed = 0;
  int  sent_random = 0;
  int  n_full = 0;
  int  n_miss = 0;
  int  n_found = 0;
  int  longest = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;    // while set, the sender never idles
  bit  growing = 1'b1;  // biases the random mix toward filling or draining

  bounded_ordered_list_core dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Applies one request to the shadow list and returns the response it owes.
  // Only equality matters for values, so the raw 32 bits are compared.
  function automatic bol_pkg::out_beat_t serve_request(input bol_pkg::in_beat_t b);
    bol_pkg::out_beat_t r;
    int                 hit;
    int                 pos;
    int                 i;
    r.status = bol_pkg::ST_DONE;
    r.found  = 1'b0;
    pos      = int'(b.position);
    unique case (b.req_type)
      bol_pkg::REQ_APPEND: begin
        if (list_mirror.size() >= bol_pkg::CAPACITY) r.status = bol_pkg::ST_FULL;
        else list_mirror.push_back(b.value);
      end
      bol_pkg::REQ_INSERT: begin
        // The position check is made before the full check.
        if (pos < 1 || pos > list_mirror.size() + 1) r.status = bol_pkg::ST_MISS;
        else if (list_mirror.size() >= bol_pkg::CAPACITY) r.status = bol_pkg::ST_FULL;
        else list_mirror.insert(pos - 1, b.value);
      end
      bol_pkg::REQ_DELETE_POS: begin
        if (pos < 1 || pos > list_mirror.size()) r.status = bol_pkg::ST_MISS;
        else list_mirror.delete(pos - 1);
      end
      bol_pkg::REQ_DELETE_VAL, bol_pkg::REQ_SEARCH: begin
        hit = -1;
        for (i = list_mirror.size() - 1; i >= 0; i--)
          if (list_mirror[i] == b.value) hit = i;
        if (hit < 0) begin
          r.status = bol_pkg::ST_MISS;
        end else begin
          r.found = 1'b1;
          if (b.req_type == bol_pkg::REQ_DELETE_VAL) list_mirror.delete(hit);
        end
      end
      bol_pkg::REQ_CLEAR: list_mirror.delete();
      default: ;
    endcase
    r.length = bol_pkg::LEN_W'(list_mirror.size());
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [31:0] value,
                                  input int unsigned position, input int unsigned reps,
                                  input bit typed, input bol_pkg::status_code_t st,
                                  input logic fnd, input int unsigned len);
    script_row_t row;
    row.beat.req_type = op;
    row.beat.value    = value;
    row.beat.position = bol_pkg::POS_W'(position);
    row.reps          = reps;
    row.typed         = typed;
    row.want.status   = st;
    row.want.found    = fnd;
    row.want.length   = bol_pkg::LEN_W'(len);
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int unsigned gap_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Values are drawn from the list itself (to hit matches and duplicates),
  // from a handful of corner values, or from the whole 32-bit range.
  function automatic logic [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4 && list_mirror.size() != 0)
      return list_mirror[$urandom_range(0, list_mirror.size() - 1)];
    if (roll < 7) return corner_values[$urandom_range(0, 5)];
    return $urandom();
  endfunction

  // Builds one random request. Most positions are legal for the current
  // length so that inserts and deletes really move the row; the rest span
  // the whole 5-bit field.
  function automatic bol_pkg::in_beat_t next_random_request();
    bol_pkg::in_beat_t b;
    int unsigned       roll;
    int unsigned       grow_w;
    int unsigned       cut_w;
    int unsigned       n;
    n        = list_mirror.size();
    grow_w   = growing ? 30 : 10;
    cut_w    = growing ? 10 : 25;
    roll     = $urandom_range(0, 99);
    b.value  = pick_value();
    b.position = bol_pkg::POS_W'($urandom_range(0, 31));
    if (roll < grow_w) begin
      b.req_type = bol_pkg::REQ_APPEND;
    end else if (roll < 2 * grow_w) begin
      b.req_type = bol_pkg::REQ_INSERT;
      if ($urandom_range(0, 99) < 85) b.position = bol_pkg::POS_W'($urandom_range(1, n + 1));
    end else if (roll < 2 * grow_w + cut_w) begin
      b.req_type = bol_pkg::REQ_DELETE_POS;
      if (n != 0 && $urandom_range(0, 99) < 85)
        b.position = bol_pkg::POS_W'($urandom_range(1, n));
    end else if (roll < 2 * grow_w + 2 * cut_w) begin
      b.req_type = bol_pkg::REQ_DELETE_VAL;
    end else if (roll < 93) begin
      b.req_type = bol_pkg::REQ_SEARCH;
    end else if (roll < 95) begin
      b.req_type = bol_pkg::REQ_CLEAR;
    end else begin
      b.req_type = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
    end
    return b;
  endfunction

  // Presents one beat, holds it until the block takes it, then records the
  // response it owes. A typed row supplies its own response; the shadow is
  // still updated so that later rows see the right list.
  task automatic issue(input bol_pkg::in_beat_t b, input bit typed,
                       input bol_pkg::out_beat_t want);
    bol_pkg::out_beat_t owed;
    int unsigned        idle;
    idle = quiet ? 0 : gap_length();
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    req   <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    owed = serve_request(b);
    answers_due.push_back(typed ? want : owed);
  endtask

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want_v, got_v);
      errors++;
    end
  endtask

  // Response side. done marks exactly one cycle; the beat is taken at the
  // edge that ends it, so sampling at the edge sees the registered values.
  always @(posedge clk) begin : response_check
    bol_pkg::out_beat_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t unexpected response: expected none, actual status %0d found %0d length %0d",
                 $time, rsp.status, rsp.found, rsp.length);
        errors++;
      end else begin
        want = answers_due.pop_front();
        check_field("status", 32'(want.status), 32'(rsp.status));
        check_field("found",  32'(want.found),  32'(rsp.found));
        check_field("length", 32'(want.length), 32'(rsp.length));
        checked++;
        if (want.status == bol_pkg::ST_FULL) n_full++;
        if (want.status == bol_pkg::ST_MISS) n_miss++;
        if (want.found) n_found++;
        if (int'(want.length) > longest) longest = int'(want.length);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t run stopped after %0d cycles with %0d responses outstanding",
             $time, cycles, answers_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    bol_pkg::out_beat_t unused_want;
    int unsigned        phase_left;
    int unsigned        k;
    unused_want = '0;
    phase_left  = 0;

    // Scripted requests. Rows with a typed response cover the empty list,
    // the single entry, the full list and every refusal; the rest are
    // checked against the shadow.
    add_row(bol_pkg::REQ_SEARCH,     32'h0000_0000,  0, 1, 1, bol_pkg::ST_MISS, 1'b0,  0);
    add_row(bol_pkg::REQ_DELETE_POS, 32'h0000_0000,  1, 1, 1, bol_pkg::ST_MISS, 1'b0,  0);
    add_row(bol_pkg::REQ_DELETE_VAL, 32'h0000_0000,  0, 1, 1, bol_pkg::ST_MISS, 1'b0,  0);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0005,  0, 1, 1, bol_pkg::ST_MISS, 1'b0,  0);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0005,  2, 1, 1, bol_pkg::ST_MISS, 1'b0,  0);
    add_row(bol_pkg::REQ_INSERT,     32'h8000_0000,  1, 1, 1, bol_pkg::ST_DONE, 1'b0,  1);
    add_row(bol_pkg::REQ_APPEND,     32'h7fff_ffff, 31, 1, 1, bol_pkg::ST_DONE, 1'b0,  2);
    add_row(bol_pkg::REQ_SEARCH,     32'h8000_0000,  0, 1, 1, bol_pkg::ST_DONE, 1'b1,  2);
    add_row(bol_pkg::REQ_DELETE_VAL, 32'h7fff_ffff,  0, 1, 1, bol_pkg::ST_DONE, 1'b1,  1);
    add_row(bol_pkg::REQ_DELETE_POS, 32'h0000_0000,  1, 1, 1, bol_pkg::ST_DONE, 1'b0,  0);
    add_row(REQ_SPARE_LO,            32'hffff_ffff, 31, 1, 1, bol_pkg::ST_DONE, 1'b0,  0);
    add_row(bol_pkg::REQ_APPEND,     32'hffff_ffff,  0, bol_pkg::CAPACITY - 1, 0,
            bol_pkg::ST_DONE, 1'b0, 0);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0001, 16, 1, 1, bol_pkg::ST_DONE, 1'b0, 16);
    add_row(bol_pkg::REQ_APPEND,     32'h0000_0007,  0, 1, 1, bol_pkg::ST_FULL, 1'b0, 16);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0007, 17, 1, 1, bol_pkg::ST_FULL, 1'b0, 16);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0007, 18, 1, 1, bol_pkg::ST_MISS, 1'b0, 16);
    add_row(bol_pkg::REQ_DELETE_POS, 32'h0000_0000, 17, 1, 1, bol_pkg::ST_MISS, 1'b0, 16);
    add_row(bol_pkg::REQ_DELETE_POS, 32'h0000_0000, 16, 1, 1, bol_pkg::ST_DONE, 1'b0, 15);
    add_row(bol_pkg::REQ_SEARCH,     32'h0000_0001,  0, 1, 1, bol_pkg::ST_MISS, 1'b0, 15);
    add_row(bol_pkg::REQ_INSERT,     32'h5555_aaaa,  1, 1, 0, bol_pkg::ST_DONE, 1'b0,  0);
    add_row(bol_pkg::REQ_DELETE_VAL, 32'hffff_ffff,  0, 1, 1, bol_pkg::ST_DONE, 1'b1, 15);
    add_row(bol_pkg::REQ_DELETE_POS, 32'h0000_0000,  1, 1, 0, bol_pkg::ST_DONE, 1'b0,  0);
    add_row(REQ_SPARE_HI,            32'h0000_0000,  0, 1, 1, bol_pkg::ST_DONE, 1'b0, 14);
    add_row(bol_pkg::REQ_INSERT,     32'h0000_0009,  8, 1, 0, bol_pkg::ST_DONE, 1'b0,  0);
    add_row(bol_pkg::REQ_CLEAR,      32'h0000_0000,  0, 1, 1, bol_pkg::ST_DONE, 1'b0,  0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      for (k = 0; k < directed_rows[r].reps; k++) begin
        issue(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);
        sent_directed++;
      end
    end

    // Random stream in phases: each phase leans toward growing or draining
    // the list, and some phases run back to back with no idle cycles.
    while (sent_random < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 120);
        growing    = ~growing;
        quiet      = ($urandom_range(0, 3) == 0);
      end
      issue(next_random_request(), 1'b0, unused_want);
      sent_random++;
      phase_left--;
    end
    start <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d responses to %0d scripted and %0d random requests.",
             checked, sent_directed, sent_random);
    $display("Seen: %0d full refusals, %0d misses, %0d matches, list up to %0d entries.",
             n_full, n_miss, n_found, longest);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
